// ===== rtl/core/keyed_table_oldest_timestamp_evict_core_defines.svh =====
// Assertion macros shared by the keyed table RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef KEYED_TABLE_OLDEST_TIMESTAMP_EVICT_CORE_DEFINES_SVH
`define KEYED_TABLE_OLDEST_TIMESTAMP_EVICT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define KTOTE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KTOTE_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KTOTE_ASSERT(name, prop, msg)
`define KTOTE_ASSERT_NEVER(name, expr, msg)
`endif
`endif

// ===== rtl/core/ktote_pkg.sv =====
// Shared constants, operation codes and item types for the keyed table.
// No dependencies.
package ktote_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CAP_W = 7;
  localparam int OCC_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // input kind codes
  localparam logic [2:0] KIND_GET   = 3'd0;
  localparam logic [2:0] KIND_PUT   = 3'd1;
  localparam logic [2:0] KIND_INVK  = 3'd2;
  localparam logic [2:0] KIND_INVS  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // internal operation codes
  localparam logic [2:0] OP_GET   = 3'd0;
  localparam logic [2:0] OP_PUT   = 3'd1;
  localparam logic [2:0] OP_INVK  = 3'd2;
  localparam logic [2:0] OP_INVS  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_NOP   = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] source_hash;
    logic [63:0] defines_hash;
    logic [31:0] entry_point_id;
    logic [15:0] profile_id;
    logic [63:0] compile_time;
    logic [31:0] payload_in;
    logic        usable;
  } cmd_t;

  typedef struct packed {
    logic [63:0] source;
    logic [63:0] defines;
    logic [31:0] entry_point;
    logic [15:0] profile;
    logic [63:0] time_val;
    logic [31:0] payload;
    logic        usable;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [31:0]      payload_out;
    logic [63:0]      time_out;
    logic [OCC_W-1:0] occupancy;
    logic [31:0]      hits_total;
    logic [31:0]      misses_total;
    logic [31:0]      evictions_total;
  } res_t;

endpackage

// ===== rtl/core/ktote_if.sv =====
// Channel interfaces: request, result and capacity write.
// Depends on ktote_pkg.
interface ktote_in_if;
  import ktote_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] source_hash;
  logic [63:0] defines_hash;
  logic [31:0] entry_point_id;
  logic [15:0] profile_id;
  logic [63:0] compile_time;
  logic [31:0] payload_in;
  logic        usable;
  modport source (output valid, kind, source_hash, defines_hash, entry_point_id,
                  profile_id, compile_time, payload_in, usable, input ready);
  modport sink (input valid, kind, source_hash, defines_hash, entry_point_id,
                profile_id, compile_time, payload_in, usable, output ready);
endinterface

interface ktote_out_if;
  import ktote_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [31:0]      payload_out;
  logic [63:0]      time_out;
  logic [OCC_W-1:0] occupancy;
  logic [31:0]      hits_total;
  logic [31:0]      misses_total;
  logic [31:0]      evictions_total;
  modport source (output valid, hit, payload_out, time_out, occupancy, hits_total,
                  misses_total, evictions_total, input ready);
  modport sink (input valid, hit, payload_out, time_out, occupancy, hits_total,
                misses_total, evictions_total, output ready);
endinterface

interface ktote_cfg_if;
  import ktote_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/keyed_table_oldest_timestamp_evict_core.sv =====
// Top level of the keyed table with oldest-timestamp eviction.
// Depends on ktote_pkg, ktote_if, ktote_queue, ktote_front and ktote_back.
//
// Usage:
//   in_ch  : request items (get, put, invalidate key, invalidate source, clear).
//   out_ch : one result item per request, in request order.
//   cfg_ch : capacity write (7 bits); write it only while the block is idle.
// A front end decodes kind and pushes commands into a two-entry queue, so up
// to two requests are taken while the back end is busy or a result waits.
// The back end scans the 64-entry table memory one slot per cycle through a
// registered read port; that scan sets the rate. Get, put and invalidates
// pass IDLE, SCAN, DRAIN, FIN and RESP before the output register; clear and
// unknown kinds skip SCAN and DRAIN. A new command starts only after the last result.
// A put into a full table evicts the oldest entry (lowest slot on ties)
// and writes in the same finish cycle.
// Reset clears the valid bits, occupancy and counters at once and sets the
// capacity to 64; table contents need no clearing. When the receiver stalls
// the result is held in the output register, the back end waits, the queue
// fills and then in_ch.ready drops.
module keyed_table_oldest_timestamp_evict_core (
  input  logic         clk,
  input  logic         rst_n,
  ktote_in_if.sink     in_ch,
  ktote_out_if.source  out_ch,
  ktote_cfg_if.sink    cfg_ch
);
  import ktote_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  ktote_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  ktote_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (q_head)
  );

  ktote_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );
endmodule

// ===== rtl/core/ktote_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on ktote_pkg.
module ktote_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ktote_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ktote_pkg::cmd_t head_cmd
);
  import ktote_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_cmd = ent_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

// ===== rtl/core/ktote_front.sv =====
// Front end: takes request items and decodes them into queue commands.
// Depends on ktote_pkg and ktote_if.
module ktote_front (
  ktote_in_if.sink         in_ch,
  input  logic             q_full,
  output logic             q_push,
  output ktote_pkg::cmd_t  q_cmd
);
  import ktote_pkg::*;

  logic [2:0] op;

  always_comb begin
    unique case (in_ch.kind)
      KIND_GET:   op = OP_GET;
      KIND_PUT:   op = OP_PUT;
      KIND_INVK:  op = OP_INVK;
      KIND_INVS:  op = OP_INVS;
      KIND_CLEAR: op = OP_CLEAR;
      default:    op = OP_NOP;
    endcase
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign q_cmd = '{op:             op,
                   source_hash:    in_ch.source_hash,
                   defines_hash:   in_ch.defines_hash,
                   entry_point_id: in_ch.entry_point_id,
                   profile_id:     in_ch.profile_id,
                   compile_time:   in_ch.compile_time,
                   payload_in:     in_ch.payload_in,
                   usable:         in_ch.usable};
endmodule

// ===== rtl/core/ktote_back.sv =====
// Back end: table memory, scan engine, counters and result register.
// Depends on ktote_pkg, ktote_if and the assertion macro header.
`include "keyed_table_oldest_timestamp_evict_core_defines.svh"
module ktote_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ktote_pkg::cmd_t q_head,
  output logic            q_pop,
  ktote_cfg_if.sink       cfg_ch,
  ktote_out_if.source     out_ch
);
  import ktote_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [2:0]         state_r;
  cmd_t               cmd_r;
  logic [CAP_W-1:0]   cap_r;
  entry_t             mem [TABLE_ENTRIES];
  entry_t             rd_data_r;
  logic [IDX_W-1:0]   addr_r;
  logic               cmp_v_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [TABLE_ENTRIES-1:0] used_r;
  logic [CNT_W-1:0]   used_cnt_r;
  logic [31:0]        hit_cnt_r;
  logic [31:0]        miss_cnt_r;
  logic [31:0]        evict_cnt_r;

  // scan trackers
  logic               found_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic               match_use_r;
  logic [31:0]        match_pay_r;
  logic [63:0]        match_time_r;
  logic               min_v_r;
  logic [IDX_W-1:0]   min_idx_r;
  logic [63:0]        min_time_r;
  logic               free_v_r;
  logic [IDX_W-1:0]   free_idx_r;

  res_t               res_r;
  res_t               out_data_r;
  logic               out_v_r;
  logic               out_free;

  logic               cur_used;
  logic               key_eq;
  logic               src_eq;
  logic               inv_src_hit;
  logic [31:0]        effcap;
  logic               do_evict;
  logic               key_live;
  logic               put_ok;
  logic               put_new;
  logic [IDX_W-1:0]   put_idx;
  logic               get_hit;
  logic [CNT_W-1:0]   used_cnt_nxt;
  logic [31:0]        hit_cnt_nxt;
  logic [31:0]        miss_cnt_nxt;
  logic [31:0]        evict_cnt_nxt;

  // capacity register; the user must write it only while idle, the block does not enforce it
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.data;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      effcap = 32'd1;
    end else if (32'(cap_r) > 32'(TABLE_ENTRIES)) begin
      effcap = 32'(TABLE_ENTRIES);
    end else begin
      effcap = 32'(cap_r);
    end
  end

  // table memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && cmd_r.op == OP_PUT && put_ok) begin
      mem[put_idx] <= '{source:      cmd_r.source_hash,
                        defines:     cmd_r.defines_hash,
                        entry_point: cmd_r.entry_point_id,
                        profile:     cmd_r.profile_id,
                        time_val:    cmd_r.compile_time,
                        payload:     cmd_r.payload_in,
                        usable:      cmd_r.usable};
    end
    rd_data_r <= mem[addr_r];
    cmp_idx_r <= addr_r;
  end

  // compare stage
  assign cur_used    = used_r[cmp_idx_r];
  assign src_eq      = (rd_data_r.source == cmd_r.source_hash);
  assign key_eq      = src_eq && (rd_data_r.defines == cmd_r.defines_hash) &&
                       (rd_data_r.entry_point == cmd_r.entry_point_id) &&
                       (rd_data_r.profile == cmd_r.profile_id);
  assign inv_src_hit = cmp_v_r && (cmd_r.op == OP_INVS) && cur_used && src_eq;

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      found_r  <= 1'b0;
      min_v_r  <= 1'b0;
      free_v_r <= 1'b0;
    end else if (cmp_v_r) begin
      if (cur_used && key_eq && !found_r) begin
        found_r      <= 1'b1;
        match_idx_r  <= cmp_idx_r;
        match_use_r  <= rd_data_r.usable;
        match_pay_r  <= rd_data_r.payload;
        match_time_r <= rd_data_r.time_val;
      end
      // strict less-than keeps the lowest slot on ties
      if (cur_used && (!min_v_r || rd_data_r.time_val < min_time_r)) begin
        min_v_r    <= 1'b1;
        min_idx_r  <= cmp_idx_r;
        min_time_r <= rd_data_r.time_val;
      end
      if (!cur_used && !free_v_r) begin
        free_v_r   <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
    end
  end

  // finish decisions
  assign do_evict = (cmd_r.op == OP_PUT) && (32'(used_cnt_r) >= effcap) && min_v_r;
  assign key_live = found_r && !(do_evict && match_idx_r == min_idx_r);
  assign get_hit  = (cmd_r.op == OP_GET) && found_r && match_use_r;

  always_comb begin
    put_ok  = 1'b0;
    put_new = 1'b0;
    put_idx = free_idx_r;
    if (key_live) begin
      put_ok  = 1'b1;
      put_idx = match_idx_r;
    end else if (free_v_r && (!do_evict || free_idx_r < min_idx_r)) begin
      put_ok  = 1'b1;
      put_new = 1'b1;
      put_idx = free_idx_r;
    end else if (do_evict) begin
      put_ok  = 1'b1;
      put_new = 1'b1;
      put_idx = min_idx_r;
    end
  end

  always_comb begin
    used_cnt_nxt  = used_cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    case (cmd_r.op)
      OP_GET: begin
        hit_cnt_nxt  = hit_cnt_r + 32'(get_hit);
        miss_cnt_nxt = miss_cnt_r + 32'(!get_hit);
      end
      OP_PUT: begin
        used_cnt_nxt  = used_cnt_r - CNT_W'(do_evict) + CNT_W'(put_ok && put_new);
        evict_cnt_nxt = evict_cnt_r + 32'(do_evict);
      end
      OP_INVK: begin
        used_cnt_nxt = used_cnt_r - CNT_W'(found_r);
      end
      OP_CLEAR: begin
        used_cnt_nxt  = '0;
        hit_cnt_nxt   = '0;
        miss_cnt_nxt  = '0;
        evict_cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (inv_src_hit) begin
      used_r[cmp_idx_r] <= 1'b0;
    end else if (state_r == ST_FIN) begin
      case (cmd_r.op)
        OP_CLEAR: used_r <= '0;
        OP_INVK: begin
          if (found_r) used_r[match_idx_r] <= 1'b0;
        end
        OP_PUT: begin
          if (do_evict) used_r[min_idx_r] <= 1'b0;
          if (put_ok) used_r[put_idx] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer and counters
  assign out_free = !out_v_r || out_ch.ready;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      cmp_v_r     <= 1'b0;
      used_cnt_r  <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      cmp_v_r <= (state_r == ST_SCAN);
      if (inv_src_hit) used_cnt_r <= used_cnt_r - CNT_W'(1);
      unique case (state_r)
        ST_IDLE: begin
          addr_r <= '0;
          if (!q_empty) begin
            cmd_r <= q_head;
            if (q_head.op == OP_CLEAR || q_head.op == OP_NOP) begin
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          addr_r <= addr_r + IDX_W'(1);
          if (addr_r == LAST_IDX) state_r <= ST_DRAIN;
        end
        ST_DRAIN: state_r <= ST_FIN;
        ST_FIN: begin
          used_cnt_r  <= used_cnt_nxt;
          hit_cnt_r   <= hit_cnt_nxt;
          miss_cnt_r  <= miss_cnt_nxt;
          evict_cnt_r <= evict_cnt_nxt;
          res_r <= '{hit:             get_hit,
                     payload_out:     get_hit ? match_pay_r : 32'd0,
                     time_out:        get_hit ? match_time_r : 64'd0,
                     occupancy:       OCC_W'(used_cnt_nxt),
                     hits_total:      hit_cnt_nxt,
                     misses_total:    miss_cnt_nxt,
                     evictions_total: evict_cnt_nxt};
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (state_r == ST_RESP && out_free) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESP && out_free) out_data_r <= res_r;
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.hit             = out_data_r.hit;
  assign out_ch.payload_out     = out_data_r.payload_out;
  assign out_ch.time_out        = out_data_r.time_out;
  assign out_ch.occupancy       = out_data_r.occupancy;
  assign out_ch.hits_total      = out_data_r.hits_total;
  assign out_ch.misses_total    = out_data_r.misses_total;
  assign out_ch.evictions_total = out_data_r.evictions_total;

  `KTOTE_ASSERT(a_cnt_matches_bits, ($countones(used_r) == 32'(used_cnt_r)), "count mismatch")
  `KTOTE_ASSERT(a_scan_pipe, (state_r == ST_SCAN) |=> (cmp_v_r && cmp_idx_r == $past(addr_r)), "scan pipe")
  `KTOTE_ASSERT(a_resp_load, (state_r == ST_RESP && out_free) |=> (state_r == ST_IDLE && out_v_r), "result lost")
  `KTOTE_ASSERT_NEVER(a_pop_busy, (q_pop && state_r != ST_IDLE), "pop while busy")
endmodule

// ===== bench/ktote_tb_pkg.sv =====
// Testbench-side types for the keyed table bench: request and result items.
// Depends on ktote_pkg.
package ktote_tb_pkg;
  import ktote_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] source_hash;
    logic [63:0] defines_hash;
    logic [31:0] entry_point_id;
    logic [15:0] profile_id;
    logic [63:0] compile_time;
    logic [31:0] payload_in;
    logic        usable;
  } request_t;

  typedef struct {
    logic             hit;
    logic [31:0]      payload_out;
    logic [63:0]      time_out;
    logic [OCC_W-1:0] occupancy;
    logic [31:0]      hits_total;
    logic [31:0]      misses_total;
    logic [31:0]      evictions_total;
  } lookup_result_t;
endpackage

// ===== bench/keyed_table_oldest_timestamp_evict_core_test.sv =====
// Bench for the keyed table with oldest-timestamp eviction: directed and random
// gets, puts, invalidates and clears, checked against a behavioral table model.
// Depends on ktote_pkg, ktote_tb_pkg, ktote_if and the core RTL.
module keyed_table_oldest_timestamp_evict_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ktote_pkg::*;
  import ktote_tb_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  ktote_in_if  in_ch ();
  ktote_out_if out_ch ();
  ktote_cfg_if cfg_ch ();

  keyed_table_oldest_timestamp_evict_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // ---- table model state ----
  logic        tbl_used    [TABLE_ENTRIES];
  logic [63:0] tbl_source  [TABLE_ENTRIES];
  logic [63:0] tbl_defines [TABLE_ENTRIES];
  logic [31:0] tbl_entry   [TABLE_ENTRIES];
  logic [15:0] tbl_profile [TABLE_ENTRIES];
  logic [63:0] tbl_time    [TABLE_ENTRIES];
  logic [31:0] tbl_payload [TABLE_ENTRIES];
  logic        tbl_usable  [TABLE_ENTRIES];
  int unsigned tbl_count;
  logic [31:0] hit_cnt, miss_cnt, evict_cnt;
  logic [CAP_W-1:0] capacity_reg;

  lookup_result_t expected_results[$];
  int  error_count = 0;
  int  send_idle_pct = 0;   // sender idle chance, percent
  int  recv_idle_pct = 0;   // receiver stall chance, percent
  int  quiet_cycles = 0;

  // small key pool so random traffic hits, overwrites and evicts often
  logic [63:0] pool_source  [8];
  logic [63:0] pool_defines [4];
  logic [31:0] pool_entry   [4];
  logic [15:0] pool_profile [4];

  function automatic int find_slot(request_t r);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_used[i] && tbl_source[i] == r.source_hash && tbl_defines[i] == r.defines_hash &&
          tbl_entry[i] == r.entry_point_id && tbl_profile[i] == r.profile_id)
        return i;
    return -1;
  endfunction

  // Apply one request to the model; return the result the block should emit.
  function automatic lookup_result_t table_apply(request_t r);
    lookup_result_t res;
    int s;
    int pick;
    int unsigned cap;
    res = '{default: '0};
    case (r.kind)
      KIND_GET: begin
        s = find_slot(r);
        if (s >= 0 && tbl_usable[s]) begin
          res.hit = 1'b1;
          res.payload_out = tbl_payload[s];
          res.time_out = tbl_time[s];
          hit_cnt++;
        end else begin
          miss_cnt++;
        end
      end
      KIND_PUT: begin
        cap = (capacity_reg == 0) ? 1 : (capacity_reg > TABLE_ENTRIES) ? TABLE_ENTRIES
                                                                         : capacity_reg;
        if (tbl_count >= cap) begin
          // oldest goes, even if the key is stored; ties to lowest slot
          pick = -1;
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_used[i] && (pick < 0 || tbl_time[i] < tbl_time[pick])) pick = i;
          if (pick >= 0) begin
            tbl_used[pick] = 1'b0;
            tbl_count--;
            evict_cnt++;
          end
        end
        s = find_slot(r);
        if (s < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!tbl_used[i]) begin
              s = i;
              break;
            end
          if (s >= 0) begin
            tbl_used[s] = 1'b1;
            tbl_count++;
          end
        end
        if (s >= 0) begin
          tbl_source[s] = r.source_hash;
          tbl_defines[s] = r.defines_hash;
          tbl_entry[s] = r.entry_point_id;
          tbl_profile[s] = r.profile_id;
          tbl_time[s] = r.compile_time;
          tbl_payload[s] = r.payload_in;
          tbl_usable[s] = r.usable;
        end
      end
      KIND_INVK: begin
        s = find_slot(r);
        if (s >= 0) begin
          tbl_used[s] = 1'b0;
          tbl_count--;
        end
      end
      KIND_INVS: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (tbl_used[i] && tbl_source[i] == r.source_hash) begin
            tbl_used[i] = 1'b0;
            tbl_count--;
          end
      end
      KIND_CLEAR: begin
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        tbl_count = 0;
        hit_cnt = 0;
        miss_cnt = 0;
        evict_cnt = 0;
      end
      default: ;  // unknown kinds change nothing
    endcase
    res.occupancy = tbl_count[OCC_W-1:0];
    res.hits_total = hit_cnt;
    res.misses_total = miss_cnt;
    res.evictions_total = evict_cnt;
    return res;
  endfunction

  // ---- drivers ----
  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.source_hash = '0;
    in_ch.defines_hash = '0;
    in_ch.entry_point_id = '0;
    in_ch.profile_id = '0;
    in_ch.compile_time = '0;
    in_ch.payload_in = '0;
    in_ch.usable = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  // valid stays high after an accept unless the sender idles or stops
  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= r.kind;
    in_ch.source_hash <= r.source_hash;
    in_ch.defines_hash <= r.defines_hash;
    in_ch.entry_point_id <= r.entry_point_id;
    in_ch.profile_id <= r.profile_id;
    in_ch.compile_time <= r.compile_time;
    in_ch.payload_in <= r.payload_in;
    in_ch.usable <= r.usable;
    do @(posedge clk); while (!in_ch.ready);
    // prediction taken at acceptance, in order
    expected_results.push_back(table_apply(r));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    capacity_reg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic request_t pool_request(logic [2:0] kind);
    request_t r;
    r.kind = kind;
    r.source_hash = pool_source[$urandom_range(7)];
    r.defines_hash = pool_defines[$urandom_range(3)];
    r.entry_point_id = pool_entry[$urandom_range(3)];
    r.profile_id = pool_profile[$urandom_range(3)];
    // narrow time range forces ties; sometimes extremes
    case ($urandom_range(9))
      0: r.compile_time = '1;
      1: r.compile_time = '0;
      2: r.compile_time = {$urandom, $urandom};
      default: r.compile_time = 64'($urandom_range(15));
    endcase
    r.payload_in = $urandom;
    r.usable = ($urandom_range(9) != 0);
    return r;
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.kind = 3'($urandom);
    r.source_hash = {$urandom, $urandom};
    r.defines_hash = {$urandom, $urandom};
    r.entry_point_id = $urandom;
    r.profile_id = 16'($urandom);
    r.compile_time = {$urandom, $urandom};
    r.payload_in = $urandom;
    r.usable = 1'($urandom);
    return r;
  endfunction

  // ---- result checker ----
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        lookup_result_t e;
        e = expected_results.pop_front();
        if (out_ch.hit !== e.hit) begin
          $error("hit: expected %0d got %0d", e.hit, out_ch.hit); error_count++;
        end
        if (out_ch.payload_out !== e.payload_out) begin
          $error("payload_out: expected %0h got %0h", e.payload_out, out_ch.payload_out);
          error_count++;
        end
        if (out_ch.time_out !== e.time_out) begin
          $error("time_out: expected %0h got %0h", e.time_out, out_ch.time_out);
          error_count++;
        end
        if (out_ch.occupancy !== e.occupancy) begin
          $error("occupancy: expected %0d got %0d", e.occupancy, out_ch.occupancy);
          error_count++;
        end
        if (out_ch.hits_total !== e.hits_total) begin
          $error("hits_total: expected %0d got %0d", e.hits_total, out_ch.hits_total);
          error_count++;
        end
        if (out_ch.misses_total !== e.misses_total) begin
          $error("misses_total: expected %0d got %0d", e.misses_total, out_ch.misses_total);
          error_count++;
        end
        if (out_ch.evictions_total !== e.evictions_total) begin
          $error("evictions_total: expected %0d got %0d", e.evictions_total,
                 out_ch.evictions_total);
          error_count++;
        end
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: no handshake on any channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---- tests ----
  task automatic test_directed();
    request_t r;
    // get on empty table, then put/get with all-ones and all-zero fields
    r = '{kind: KIND_GET, source_hash: '1, defines_hash: '1, entry_point_id: '1,
          profile_id: '1, compile_time: '1, payload_in: '1, usable: 1'b1};
    send_request(r);
    r.kind = KIND_PUT; send_request(r);
    r.kind = KIND_GET; send_request(r);
    r = '{kind: KIND_PUT, source_hash: '0, defines_hash: '0, entry_point_id: '0,
          profile_id: '0, compile_time: '0, payload_in: '0, usable: 1'b1};
    send_request(r);
    r.kind = KIND_GET; send_request(r);
    // unusable entry reads as a miss
    r.kind = KIND_PUT; r.usable = 1'b0; r.payload_in = 32'h5a5a_a5a5; send_request(r);
    r.kind = KIND_GET; send_request(r);
    // invalidate present and absent key
    r.kind = KIND_INVK; send_request(r);
    send_request(r);
    // invalidate by source
    r = '{kind: KIND_PUT, source_hash: 64'h77, defines_hash: 64'h1, entry_point_id: 32'h2,
          profile_id: 16'h3, compile_time: 64'h10, payload_in: 32'h11, usable: 1'b1};
    send_request(r);
    r.defines_hash = 64'h9; send_request(r);
    r.kind = KIND_INVS; send_request(r);
    // unknown kinds
    for (int k = 5; k < 8; k++) begin
      r.kind = 3'(k); send_request(r);
    end
    r.kind = KIND_CLEAR; send_request(r);
    r.kind = KIND_GET; send_request(r);
  endtask

  task automatic test_eviction_ties();
    request_t r;
    write_capacity(7'd2);
    // all-ones times tie: lowest slot goes
    for (int i = 0; i < 4; i++) begin
      r = '{kind: KIND_PUT, source_hash: 64'(i), defines_hash: 0, entry_point_id: 0,
            profile_id: 0, compile_time: '1, payload_in: 32'(i), usable: 1'b1};
      send_request(r);
    end
    // key already stored in a full table still forces eviction
    r.compile_time = 64'h5; send_request(r);
    r.kind = KIND_GET; send_request(r);
    // capacity below occupancy
    write_capacity(7'd64);
    for (int i = 0; i < 6; i++) begin
      r = pool_request(KIND_PUT); send_request(r);
    end
    write_capacity(7'd0);
    repeat (3) begin
      r = pool_request(KIND_PUT); send_request(r);
    end
    r.kind = KIND_CLEAR; send_request(r);
  endtask

  task automatic test_random(int count, logic [CAP_W-1:0] cap);
    request_t r;
    int pick;
    write_capacity(cap);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) r = noise_request();
      else if (pick < 45) r = pool_request(KIND_GET);
      else if (pick < 85) r = pool_request(KIND_PUT);
      else if (pick < 93) r = pool_request(KIND_INVK);
      else if (pick < 98) r = pool_request(KIND_INVS);
      else r = pool_request(KIND_CLEAR);
      send_request(r);
      // hold off once mid-phase until everything has drained
      if (n == count / 2) begin
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    foreach (pool_source[i]) pool_source[i] = {$urandom, $urandom};
    foreach (pool_defines[i]) pool_defines[i] = {$urandom, $urandom};
    foreach (pool_entry[i]) pool_entry[i] = $urandom;
    foreach (pool_profile[i]) pool_profile[i] = 16'($urandom);
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    tbl_count = 0; hit_cnt = 0; miss_cnt = 0; evict_cnt = 0;
    capacity_reg = CAP_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9; recv_idle_pct = 65;
    test_directed();
    test_eviction_ties();
    test_random(200, 7'd1);
    test_random(250, 7'd127);
    send_idle_pct = 65; recv_idle_pct = 9;
    test_random(250, 7'd5);
    test_random(200, 7'd64);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(200, 7'd3);
    test_random(200, 7'd40);

    wait_idle();
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
